// ----- hdl/csr_pkg.sv -----
// Shared definitions for the cache set replacement block.
// Holds action and policy codes and the command structs driven into the cells.
// No dependencies.
package csr_pkg;

    localparam logic [1:0] ACT_READ       = 2'd0;
    localparam logic [1:0] ACT_WRITE      = 2'd1;
    localparam logic [1:0] ACT_ALLOCATE   = 2'd2;
    localparam logic [1:0] ACT_INVALIDATE = 2'd3;

    localparam logic POL_LRU  = 1'b0;
    localparam logic POL_FIFO = 1'b1;

    localparam logic REG_POLICY = 1'b0;

    typedef struct packed {
        logic fill;
        logic set_dirty;
        logic clear;
        logic touch;
        logic dirty_val;
    } csr_way_cmd_t;

    typedef struct packed {
        logic remove;
        logic push;
    } csr_queue_cmd_t;

endpackage

// ----- hdl/csr_way_cell.sv -----
// One way of the set: tag, valid, dirty and recency rank.
// Joins the hit, free-way and least-recent search chains; uses csr_pkg.
module csr_way_cell #(
    parameter int WAY       = 0,
    parameter int ASSOC     = 8,
    parameter int TAG_WIDTH = 24,
    parameter int WW        = 3,
    parameter int RW        = 3
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  csr_pkg::csr_way_cmd_t cmd,
    input  logic [WW-1:0]         cmd_way,
    input  logic [TAG_WIDTH-1:0]  cmd_tag,
    input  logic [RW-1:0]         touch_rank,
    input  logic [TAG_WIDTH-1:0]  look_tag,
    input  logic                  hit_in,
    input  logic [WW-1:0]         hit_idx_in,
    output logic                  hit_out,
    output logic [WW-1:0]         hit_idx_out,
    input  logic                  free_in,
    input  logic [WW-1:0]         free_idx_in,
    output logic                  free_out,
    output logic [WW-1:0]         free_idx_out,
    input  logic                  lru_has_in,
    input  logic [RW-1:0]         lru_rank_in,
    input  logic [WW-1:0]         lru_idx_in,
    output logic                  lru_has_out,
    output logic [RW-1:0]         lru_rank_out,
    output logic [WW-1:0]         lru_idx_out,
    output logic [TAG_WIDTH-1:0]  tag,
    output logic                  valid,
    output logic                  dirty,
    output logic [RW-1:0]         rank
);

    localparam logic [WW-1:0] MY_IDX   = WW'(WAY);
    localparam logic [RW-1:0] TOP_RANK = RW'(ASSOC - 1);

    logic [TAG_WIDTH-1:0] tag_reg;
    logic                 valid_reg;
    logic                 dirty_reg;
    logic [RW-1:0]        rank_reg;
    logic                 sel;
    logic                 match;
    logic                 take_lru;

    assign sel   = (cmd_way == MY_IDX);
    assign match = valid_reg && (tag_reg == look_tag);

    assign hit_out     = hit_in || match;
    assign hit_idx_out = hit_in ? hit_idx_in : MY_IDX;

    assign free_out     = free_in || !valid_reg;
    assign free_idx_out = free_in ? free_idx_in : MY_IDX;

    assign take_lru     = !lru_has_in || (rank_reg < lru_rank_in);
    assign lru_has_out  = 1'b1;
    assign lru_rank_out = take_lru ? rank_reg : lru_rank_in;
    assign lru_idx_out  = take_lru ? MY_IDX : lru_idx_in;

    always_ff @(posedge aclk) begin
        if (cmd.fill && sel) begin
            tag_reg <= cmd_tag;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            dirty_reg <= 1'b0;
            rank_reg  <= '0;
        end else begin
            if (sel && cmd.fill) begin
                valid_reg <= 1'b1;
                dirty_reg <= cmd.dirty_val;
            end else if (sel && cmd.set_dirty) begin
                dirty_reg <= 1'b1;
            end else if (sel && cmd.clear) begin
                valid_reg <= 1'b0;
                dirty_reg <= 1'b0;
            end
            if (cmd.touch) begin
                if (sel) begin
                    rank_reg <= TOP_RANK;
                end else if (rank_reg > touch_rank) begin
                    rank_reg <= rank_reg - 1'b1;
                end
            end
        end
    end

    assign tag   = tag_reg;
    assign valid = valid_reg;
    assign dirty = dirty_reg;
    assign rank  = rank_reg;

endmodule

// ----- hdl/csr_queue_cell.sv -----
// One place of the fill-order queue, holding a way index.
// Shifts from its right-hand neighbour on removal; uses csr_pkg.
module csr_queue_cell #(
    parameter int POS = 0,
    parameter int WW  = 3,
    parameter int CW  = 4
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  csr_pkg::csr_queue_cmd_t cmd,
    input  logic [WW-1:0]           cmd_way,
    input  logic [CW-1:0]           count,
    input  logic [CW-1:0]           push_pos,
    input  logic [WW-1:0]           right_val,
    input  logic                    found_in,
    output logic                    found_out,
    output logic [WW-1:0]           val
);

    localparam logic [CW-1:0] MY_POS = CW'(POS);

    logic [WW-1:0] val_reg;
    logic          match;

    assign match     = (val_reg == cmd_way) && (MY_POS < count);
    assign found_out = found_in || match;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            val_reg <= '0;
        end else if (cmd.push && (push_pos == MY_POS)) begin
            val_reg <= cmd_way;
        end else if (cmd.remove && found_out) begin
            val_reg <= right_val;
        end
    end

    assign val = val_reg;

endmodule

// ----- hdl/cache_set_replacement.sv -----
// Cache set replacement: one set of ASSOC ways with LRU or FIFO victim choice.
// Each item passes a lookup state over the row of way cells, then an update
// state that writes the cells and the queue; the update waits while a held
// result is not taken, and the next item can be accepted as it goes ahead.
// Reset (aresetn low, synchronous) clears valid, dirty, ranks, queue and policy.
module cache_set_replacement #(
    parameter int ASSOC     = 8,
    parameter int TAG_WIDTH = 24
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_action,
    input  logic [TAG_WIDTH-1:0] s_tag,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_hit,
    output logic [2:0]           m_way,
    output logic                 m_victim_valid,
    output logic [TAG_WIDTH-1:0] m_victim_tag,
    output logic                 m_victim_dirty
);

    localparam int WW = (ASSOC > 1) ? $clog2(ASSOC) : 1;
    localparam int RW = WW;
    localparam int CW = $clog2(ASSOC + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOOK = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;

    logic [1:0]           state_reg, state_next;
    logic                 policy_reg;
    logic [1:0]           act_reg;
    logic [TAG_WIDTH-1:0] tag_reg;
    logic                 hit_reg, free_reg;
    logic [WW-1:0]        hit_way_reg, free_way_reg, lru_way_reg;
    logic [CW-1:0]        count_reg, count_next;

    logic                 m_valid_reg;
    logic                 m_hit_reg, m_victim_valid_reg, m_victim_dirty_reg;
    logic [2:0]           m_way_reg;
    logic [TAG_WIDTH-1:0] m_victim_tag_reg;

    logic [ASSOC:0]       hit_c, free_c, lru_has_c, found_c;
    logic [WW-1:0]        hit_idx_c [ASSOC+1];
    logic [WW-1:0]        free_idx_c [ASSOC+1];
    logic [WW-1:0]        lru_idx_c [ASSOC+1];
    logic [RW-1:0]        lru_rank_c [ASSOC+1];

    logic [TAG_WIDTH-1:0] tag_arr [ASSOC];
    logic [RW-1:0]        rank_arr [ASSOC];
    logic [ASSOC-1:0]     valid_vec, dirty_vec;
    logic [WW-1:0]        qval [ASSOC];

    csr_pkg::csr_way_cmd_t   way_cmd;
    csr_pkg::csr_queue_cmd_t q_cmd;

    logic          accept, upd_go;
    logic          is_wr, is_alloc, is_inv, do_fill, evict, fifo_ok;
    logic [WW-1:0] victim_way, tgt_way;
    logic [CW-1:0] count_after, push_pos;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == csr_pkg::REG_POLICY) ? {31'd0, policy_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            policy_reg <= csr_pkg::POL_LRU;
        end else if (psel && penable && pwrite && (paddr[2] == csr_pkg::REG_POLICY)) begin
            policy_reg <= pwdata[0];
        end
    end

    assign upd_go  = (state_reg == S_UPD) && (!m_valid_reg || m_ready);
    assign s_ready = (state_reg == S_IDLE) || upd_go;
    assign accept  = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) state_next = S_LOOK;
            end
            S_LOOK: state_next = S_UPD;
            S_UPD: begin
                if (upd_go) state_next = accept ? S_LOOK : S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            act_reg <= s_action;
            tag_reg <= s_tag;
        end
        if (state_reg == S_LOOK) begin
            hit_reg      <= hit_c[ASSOC];
            hit_way_reg  <= hit_idx_c[ASSOC];
            free_reg     <= free_c[ASSOC];
            free_way_reg <= free_idx_c[ASSOC];
            lru_way_reg  <= lru_idx_c[ASSOC];
        end
    end

    assign hit_c[0]      = 1'b0;
    assign hit_idx_c[0]  = '0;
    assign free_c[0]     = 1'b0;
    assign free_idx_c[0] = '0;
    assign lru_has_c[0]  = 1'b0;
    assign lru_rank_c[0] = '0;
    assign lru_idx_c[0]  = '0;
    assign found_c[0]    = 1'b0;

    genvar g;
    generate
        for (g = 0; g < ASSOC; g++) begin : g_way
            csr_way_cell #(
                .WAY(g), .ASSOC(ASSOC), .TAG_WIDTH(TAG_WIDTH), .WW(WW), .RW(RW)
            ) u_cell (
                .aclk(aclk), .aresetn(aresetn),
                .cmd(way_cmd), .cmd_way(tgt_way), .cmd_tag(tag_reg),
                .touch_rank(rank_arr[tgt_way]), .look_tag(tag_reg),
                .hit_in(hit_c[g]), .hit_idx_in(hit_idx_c[g]),
                .hit_out(hit_c[g+1]), .hit_idx_out(hit_idx_c[g+1]),
                .free_in(free_c[g]), .free_idx_in(free_idx_c[g]),
                .free_out(free_c[g+1]), .free_idx_out(free_idx_c[g+1]),
                .lru_has_in(lru_has_c[g]), .lru_rank_in(lru_rank_c[g]),
                .lru_idx_in(lru_idx_c[g]),
                .lru_has_out(lru_has_c[g+1]), .lru_rank_out(lru_rank_c[g+1]),
                .lru_idx_out(lru_idx_c[g+1]),
                .tag(tag_arr[g]), .valid(valid_vec[g]), .dirty(dirty_vec[g]),
                .rank(rank_arr[g])
            );

            csr_queue_cell #(.POS(g), .WW(WW), .CW(CW)) u_queue (
                .aclk(aclk), .aresetn(aresetn),
                .cmd(q_cmd), .cmd_way(tgt_way), .count(count_reg),
                .push_pos(push_pos),
                .right_val((g == ASSOC - 1) ? qval[g] : qval[(g + 1) % ASSOC]),
                .found_in(found_c[g]), .found_out(found_c[g+1]), .val(qval[g])
            );
        end
    endgenerate

    assign is_wr    = (act_reg == csr_pkg::ACT_WRITE);
    assign is_alloc = (act_reg == csr_pkg::ACT_ALLOCATE);
    assign is_inv   = (act_reg == csr_pkg::ACT_INVALIDATE);
    assign do_fill  = (is_wr || is_alloc) && !hit_reg;
    assign evict    = do_fill && !free_reg;

    assign fifo_ok    = (count_reg != '0) && ({1'b0, qval[0]} < (WW+1)'(ASSOC));
    assign victim_way = (policy_reg == csr_pkg::POL_FIFO) ? (fifo_ok ? qval[0] : '0)
                                                           : lru_way_reg;

    always_comb begin
        if (hit_reg) begin
            tgt_way = hit_way_reg;
        end else if (do_fill) begin
            tgt_way = free_reg ? free_way_reg : victim_way;
        end else begin
            tgt_way = '0;
        end
    end

    assign way_cmd.fill      = upd_go && do_fill;
    assign way_cmd.set_dirty = upd_go && is_wr && hit_reg;
    assign way_cmd.clear     = upd_go && is_inv && hit_reg;
    assign way_cmd.touch     = upd_go && (do_fill || (is_wr && hit_reg));
    assign way_cmd.dirty_val = is_wr;

    assign q_cmd.remove = upd_go && ((is_inv && hit_reg) || evict);
    assign q_cmd.push   = upd_go && do_fill;

    assign count_after = (q_cmd.remove && found_c[ASSOC]) ? count_reg - 1'b1 : count_reg;
    assign push_pos    = (count_after < CW'(ASSOC)) ? count_after : CW'(ASSOC);
    assign count_next  = (q_cmd.push && (count_after < CW'(ASSOC))) ? count_after + 1'b1
                                                                     : count_after;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (upd_go) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (upd_go) begin
            m_hit_reg          <= hit_reg;
            m_way_reg          <= 3'(tgt_way);
            m_victim_valid_reg <= evict;
            m_victim_tag_reg   <= evict ? tag_arr[victim_way] : '0;
            m_victim_dirty_reg <= evict && dirty_vec[victim_way];
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_hit          = m_hit_reg;
    assign m_way          = m_way_reg;
    assign m_victim_valid = m_victim_valid_reg;
    assign m_victim_tag   = m_victim_tag_reg;
    assign m_victim_dirty = m_victim_dirty_reg;

    a_count_tracks_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (CW'($countones(valid_vec)) == count_reg))
        else $error("Queue length differs from the number of valid ways.");

    a_evict_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (upd_go && evict) |-> (&valid_vec))
        else $error("Eviction while a way was still free.");

    a_queue_head_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != '0) |-> valid_vec[qval[0]])
        else $error("Oldest queued way is not valid.");

    a_result_follows_item: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == S_LOOK))
        else $error("Accepted item did not enter the lookup cycle.");

endmodule
